// ===== rtl/pwsl_pkg.sv =====
// Shared types, constants and sizes for the pulse-width serial link.
package pwsl_pkg;

   // Buffer depths and derived address / position widths
   localparam int TX_BYTES = 16;
   localparam int RX_BYTES = 16;
   localparam int TX_AW    = (TX_BYTES > 1) ? $clog2(TX_BYTES) : 1;
   localparam int RX_AW    = (RX_BYTES > 1) ? $clog2(RX_BYTES) : 1;
   localparam int RX_PW    = $clog2(RX_BYTES + 1);

   // Transmit period lengths in ticks
   localparam logic [4:0] TX_LOW_TICKS  = 5'd5;
   localparam logic [4:0] TX_ZERO_TICKS = 5'd10;
   localparam logic [4:0] TX_ONE_TICKS  = 5'd15;
   localparam logic [4:0] TX_HEAD_TICKS = 5'd20;

   // Receive width windows in ticks between falling edges
   localparam logic [7:0] RX_HEAD_MIN = 8'd17;
   localparam logic [7:0] RX_HEAD_MAX = 8'd23;
   localparam logic [7:0] RX_ONE_MIN  = 8'd13;
   localparam logic [7:0] RX_ONE_MAX  = 8'd17;
   localparam logic [7:0] RX_ZERO_MIN = 8'd8;
   localparam logic [7:0] RX_ZERO_MAX = 8'd12;

   // Request kinds
   typedef enum logic [1:0] {
      FN_TICK  = 2'd0,
      FN_WRITE = 2'd1,
      FN_READ  = 2'd2,
      FN_CLEAR = 2'd3
   } func_type;

   // Transmitter frame phases
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HEAD = 2'd1,
      PH_DATA = 2'd2,
      PH_END  = 2'd3
   } tx_phase_type;

   // One request as it travels through the pipeline
   typedef struct packed {
      func_type    func;
      logic        rx_line;
      logic [5:0]  index;
      logic [7:0]  wr_data;
      logic        last;
   } item_type;

   // Transmitter status after a request
   typedef struct packed {
      logic tx_line;
      logic tx_busy;
   } tx_status_type;

   // Receiver status after a request
   typedef struct packed {
      logic       rx_done;
      logic [7:0] rd_data;
   } rx_status_type;

endpackage

// ===== rtl/pwsl_tx.sv =====
// Transmitter: frame sequencer around the transmit buffer memory.
module pwsl_tx
   import pwsl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          exec,
   input  item_type      cur_item,
   output tx_status_type status
);

   logic [7:0]       mem [TX_BYTES];
   logic [TX_BYTES-1:0] vld_ff;
   logic [7:0]       rdata_ff;
   logic             rvld_ff;
   logic             byp_ff;
   logic [7:0]       byp_data_ff;
   logic [7:0]       cur_byte;

   logic [4:0]       cnt_ff, cnt_in;
   logic [7:0]       mask_ff, mask_in;
   logic [TX_AW-1:0] pos_ff, pos_in;
   tx_phase_type     phase_ff, phase_in;
   logic             enable_ff, enable_in;
   logic             level_ff, level_in;

   logic             we;
   logic [TX_AW-1:0] wa;
   logic [4:0]       limit;
   logic [TX_AW:0]   pos_next;

   // Hold the byte at the current position, with write forwarding
   assign cur_byte = byp_ff ? byp_data_ff : (rvld_ff ? rdata_ff : 8'd0);
   assign wa       = cur_item.index[TX_AW-1:0];

   // Frame sequencer and host writes
   always_comb begin
      cnt_in    = cnt_ff;
      mask_in   = mask_ff;
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      enable_in = enable_ff;
      level_in  = level_ff;
      we        = 1'b0;
      limit     = TX_ZERO_TICKS;
      pos_next  = {1'b0, pos_ff} + 1'b1;
      if (exec) begin
         case (cur_item.func)
            FN_TICK: begin
               if (enable_ff) begin
                  cnt_in = cnt_ff + 5'd1;
                  case (phase_ff)
                     PH_DATA: begin
                        limit = (|(cur_byte & mask_ff)) ? TX_ONE_TICKS : TX_ZERO_TICKS;
                        if (cnt_in > limit) begin
                           cnt_in  = 5'd1;
                           mask_in = {mask_ff[6:0], 1'b0};
                        end
                        if (mask_in == 8'd0) begin
                           mask_in = 8'd1;
                           if (pos_next >= (TX_AW+1)'(TX_BYTES)) begin
                              cnt_in   = 5'd1;
                              pos_in   = '0;
                              phase_in = PH_END;
                           end else begin
                              pos_in = pos_next[TX_AW-1:0];
                           end
                        end
                     end
                     PH_HEAD: begin
                        if (cnt_in > TX_HEAD_TICKS) begin
                           cnt_in   = 5'd1;
                           mask_in  = 8'd1;
                           phase_in = PH_DATA;
                        end
                     end
                     PH_END: begin
                        if (cnt_in > TX_ZERO_TICKS) begin
                           phase_in  = PH_IDLE;
                           enable_in = 1'b0;
                        end
                     end
                     default: ;
                  endcase
                  level_in = (cnt_in > TX_LOW_TICKS);
               end
            end
            FN_WRITE: begin
               if ({1'b0, cur_item.index} < 7'(TX_BYTES)) begin
                  we = 1'b1;
                  if (cur_item.last) begin
                     cnt_in    = 5'd0;
                     phase_in  = PH_HEAD;
                     enable_in = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 5'd0;
         mask_ff   <= 8'd0;
         pos_ff    <= '0;
         phase_ff  <= PH_IDLE;
         enable_ff <= 1'b0;
         level_ff  <= 1'b1;
      end else begin
         cnt_ff    <= cnt_in;
         mask_ff   <= mask_in;
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         enable_ff <= enable_in;
         level_ff  <= level_in;
      end
   end

   // Transmit buffer: write port, and read of the next position
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= cur_item.wr_data;
      end
      rdata_ff    <= mem[pos_in];
      byp_data_ff <= cur_item.wr_data;
   end

   // Entry valid bits and forwarding flags
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         rvld_ff <= 1'b0;
         byp_ff  <= 1'b0;
      end else begin
         if (we) begin
            vld_ff[wa] <= 1'b1;
         end
         rvld_ff <= vld_ff[pos_in];
         byp_ff  <= we && (wa == pos_in);
      end
   end

   assign status.tx_line = level_in;
   assign status.tx_busy = enable_in;

endmodule

// ===== rtl/pwsl_rx.sv =====
// Receiver: edge-width decoder with read-modify-write of the receive buffer memory.
module pwsl_rx
   import pwsl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          exec,
   input  item_type      cur_item,
   input  item_type      nxt_item,
   output rx_status_type status
);

   logic [7:0]       mem [RX_BYTES];
   logic [RX_BYTES-1:0] vld_ff;
   logic [7:0]       rdata_ff;
   logic             rvld_ff;
   logic             byp_ff;
   logic [7:0]       byp_data_ff;
   logic [7:0]       cur_byte;

   logic [7:0]       mask_ff, mask_in;
   logic [RX_PW-1:0] pos_ff, pos_in;
   logic [7:0]       wc_ff, wc_in;
   logic             active_ff, active_in;
   logic             complete_ff, complete_in;
   logic             prev_ff, prev_in;

   logic             we;
   logic [RX_AW-1:0] wa;
   logic [7:0]       wd;
   logic [RX_AW-1:0] ra;
   logic             advance;
   logic [7:0]       rd;

   // Hold the addressed byte, with write forwarding
   assign cur_byte = byp_ff ? byp_data_ff : (rvld_ff ? rdata_ff : 8'd0);
   assign wa       = pos_ff[RX_AW-1:0];

   // Address the host byte for a read, else the byte being filled
   assign ra = (nxt_item.func == FN_READ) ? nxt_item.index[RX_AW-1:0] : pos_in[RX_AW-1:0];

   // Width measurement, frame decode and host accesses
   always_comb begin
      mask_in     = mask_ff;
      pos_in      = pos_ff;
      wc_in       = wc_ff;
      active_in   = active_ff;
      complete_in = complete_ff;
      prev_in     = prev_ff;
      we          = 1'b0;
      wd          = cur_byte;
      advance     = 1'b0;
      rd          = 8'd0;
      if (exec) begin
         case (cur_item.func)
            FN_TICK: begin
               wc_in = wc_ff + 8'd1;
               if (!cur_item.rx_line) begin
                  if (prev_ff) begin
                     prev_in = 1'b0;
                     // Falling edge: classify the width just measured
                     if (wc_in inside {[RX_HEAD_MIN:RX_HEAD_MAX]}) begin
                        active_in = 1'b1;
                        mask_in   = 8'd1;
                        pos_in    = '0;
                     end else if (active_ff) begin
                        if (pos_ff >= RX_PW'(RX_BYTES)) begin
                           active_in = 1'b0;
                        end else if (wc_in inside {[RX_ONE_MIN:RX_ONE_MAX]}) begin
                           we      = 1'b1;
                           wd      = cur_byte | mask_ff;
                           advance = 1'b1;
                        end else if (wc_in inside {[RX_ZERO_MIN:RX_ZERO_MAX]}) begin
                           we      = 1'b1;
                           wd      = cur_byte & ~mask_ff;
                           advance = 1'b1;
                        end else begin
                           active_in = 1'b0;
                        end
                     end
                     // Advance to the next bit, and the next byte after bit seven
                     if (advance) begin
                        mask_in = {mask_ff[6:0], 1'b0};
                        if (mask_in == 8'd0) begin
                           mask_in = 8'd1;
                           pos_in  = pos_ff + 1'b1;
                           if (pos_in >= RX_PW'(RX_BYTES)) begin
                              complete_in = 1'b1;
                              active_in   = 1'b0;
                           end
                        end
                     end
                     wc_in = 8'd0;
                  end
               end else begin
                  prev_in = 1'b1;
               end
            end
            FN_READ: begin
               if ({1'b0, cur_item.index} < 7'(RX_BYTES)) begin
                  rd = cur_byte;
               end
            end
            FN_CLEAR: begin
               complete_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   // Decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff     <= 8'd0;
         pos_ff      <= '0;
         wc_ff       <= 8'd0;
         active_ff   <= 1'b0;
         complete_ff <= 1'b0;
         prev_ff     <= 1'b0;
      end else begin
         mask_ff     <= mask_in;
         pos_ff      <= pos_in;
         wc_ff       <= wc_in;
         active_ff   <= active_in;
         complete_ff <= complete_in;
         prev_ff     <= prev_in;
      end
   end

   // Receive buffer: write port and one read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rdata_ff    <= mem[ra];
      byp_data_ff <= wd;
   end

   // Entry valid bits and forwarding flags
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         rvld_ff <= 1'b0;
         byp_ff  <= 1'b0;
      end else begin
         if (we) begin
            vld_ff[wa] <= 1'b1;
         end
         rvld_ff <= vld_ff[ra];
         byp_ff  <= we && (wa == ra);
      end
   end

   assign status.rx_done = complete_in;
   assign status.rd_data = rd;

endmodule

// ===== rtl/pulse_width_serial_link_top.sv =====
// Top level of the pulse-width serial link: request stage, units and response buffer.
//
//   channel | ports  | tdata (low bit up)                          | side band
//   request | req_*  | rx_line, index[6], wr_data[8], zero pad     | tuser func, tlast last
//   result  | rsp_*  | tx_line, tx_busy, rx_done, rd_data[8], pad  | none
//
// One request per cycle while the response buffer has room; each result passes the
// request stage and the response buffer registers. The rate is set by the
// read-modify-write on the receive buffer: reads are issued ahead, at the position left
// by the request in flight, and a write to the same entry is forwarded. Reset clears the
// buffer valid bits, so no clearing pass is needed. A two-entry response buffer lets
// requests keep flowing while a result waits; it fills only under rsp_tready low.
module pulse_width_serial_link_top
   import pwsl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_line[0], index[6:1], wr_data[14:7], zero[15]
   input  logic [1:0]  req_tuser,   // func[1:0]
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // tx_line[0], tx_busy[1], rx_done[2], rd_data[10:3]
);

   logic          s1_valid_ff, s1_valid_in;
   item_type      s1_item_ff;
   item_type      req_item;
   item_type      nxt_item;
   logic          accept;
   logic          exec;

   tx_status_type tx_status;
   rx_status_type rx_status;
   logic [10:0]   result;

   logic          out_valid_ff, out_valid_in;
   logic [10:0]   out_data_ff, out_data_in;
   logic          skid_valid_ff, skid_valid_in;
   logic [10:0]   skid_data_ff, skid_data_in;
   logic          pop;

   // Unpack the request
   assign req_item.func    = func_type'(req_tuser);
   assign req_item.rx_line = req_tdata[0];
   assign req_item.index   = req_tdata[6:1];
   assign req_item.wr_data = req_tdata[14:7];
   assign req_item.last    = req_tlast;

   // Advance the request stage while the response buffer has room
   assign exec        = s1_valid_ff && !skid_valid_ff;
   assign req_tready  = !s1_valid_ff || exec;
   assign accept      = req_tvalid && req_tready;
   assign s1_valid_in = accept || (s1_valid_ff && !exec);
   assign nxt_item    = accept ? req_item : s1_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
   end

   pwsl_tx u_tx (
      .clock    (clock),
      .reset    (reset),
      .exec     (exec),
      .cur_item (s1_item_ff),
      .status   (tx_status)
   );

   pwsl_rx u_rx (
      .clock    (clock),
      .reset    (reset),
      .exec     (exec),
      .cur_item (s1_item_ff),
      .nxt_item (nxt_item),
      .status   (rx_status)
   );

   assign result = {rx_status.rd_data, rx_status.rx_done, tx_status.tx_busy, tx_status.tx_line};

   // Response buffer: output register with a skid entry behind it
   assign pop = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop || !out_valid_ff) begin
         out_valid_in  = skid_valid_ff || exec;
         out_data_in   = skid_valid_ff ? skid_data_ff : result;
         skid_valid_in = 1'b0;
      end else if (exec) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_data_ff};

endmodule

// ===== bench/pulse_width_link_checker.sv =====
// Watches both channels of the pulse-width serial link, predicts each result and compares it.
module pulse_width_link_checker
   import pwsl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_line[0], index[6:1], wr_data[14:7], zero[15]
   input  logic [1:0]  req_tuser,   // func[1:0]
   input  logic        req_tlast,   // last
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // tx_line[0], tx_busy[1], rx_done[2], rd_data[10:3]
   output int          mismatch_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       tx_line;
      logic       tx_busy;
      logic       rx_done;
      logic [7:0] rd_data;
   } link_status_type;

   // Transmitter copy
   logic [7:0]   tx_bytes [TX_BYTES];
   logic [4:0]   tx_ticks;
   logic [7:0]   tx_mask;
   logic [5:0]   tx_pos;
   tx_phase_type tx_phase;
   logic         tx_on;
   logic         tx_level;

   // Receiver copy
   logic [7:0]   rx_bytes [RX_BYTES];
   logic [7:0]   rx_mask;
   logic [6:0]   rx_pos;
   logic [7:0]   rx_width;
   logic         rx_active;
   logic         rx_complete;
   logic         rx_prev_high;

   link_status_type status_queue[$];
   int              errors;
   int              result_count;

   // Advance the transmitter by one tick and derive the line level
   function automatic void tx_advance();
      logic [4:0] span;
      tx_ticks = tx_ticks + 5'd1;
      case (tx_phase)
         PH_DATA: begin
            span = TX_ZERO_TICKS;
            if (tx_pos < TX_BYTES) begin
               if ((tx_bytes[tx_pos] & tx_mask) != 8'd0) span = TX_ONE_TICKS;
            end
            if (tx_ticks > span) begin
               tx_ticks = 5'd1;
               tx_mask = tx_mask << 1;
            end
            if (tx_mask == 8'd0) begin
               tx_mask = 8'd1;
               if (tx_pos + 1 >= TX_BYTES) begin
                  tx_ticks = 5'd1;
                  tx_pos = 6'd0;
                  tx_phase = PH_END;
               end else begin
                  tx_pos = tx_pos + 6'd1;
               end
            end
         end
         PH_HEAD: begin
            if (tx_ticks > TX_HEAD_TICKS) begin
               tx_ticks = 5'd1;
               tx_mask = 8'd1;
               tx_phase = PH_DATA;
            end
         end
         PH_END: begin
            if (tx_ticks > TX_ZERO_TICKS) begin
               tx_phase = PH_IDLE;
               tx_on = 1'b0;
            end
         end
         default: ;
      endcase
      tx_level = (tx_ticks <= TX_LOW_TICKS) ? 1'b0 : 1'b1;
   endfunction

   // Classify the width that ends at a falling edge
   function automatic void rx_measure();
      if (rx_width >= RX_HEAD_MIN && rx_width <= RX_HEAD_MAX) begin
         rx_active = 1'b1;
         rx_mask = 8'd1;
         rx_pos = 7'd0;
         return;
      end
      if (!rx_active) return;
      if (rx_pos >= RX_BYTES) begin
         rx_active = 1'b0;
         return;
      end
      if (rx_width >= RX_ONE_MIN && rx_width <= RX_ONE_MAX) begin
         rx_bytes[rx_pos] = rx_bytes[rx_pos] | rx_mask;
      end else if (rx_width >= RX_ZERO_MIN && rx_width <= RX_ZERO_MAX) begin
         rx_bytes[rx_pos] = rx_bytes[rx_pos] & ~rx_mask;
      end else begin
         rx_active = 1'b0;
         return;
      end
      // step to the next bit, then to the next byte
      rx_mask = rx_mask << 1;
      if (rx_mask == 8'd0) begin
         rx_mask = 8'd1;
         rx_pos = rx_pos + 7'd1;
         if (rx_pos >= RX_BYTES) begin
            rx_complete = 1'b1;
            rx_active = 1'b0;
         end
      end
   endfunction

   // Sample the receive line on a tick
   function automatic void rx_sample(logic line);
      rx_width = rx_width + 8'd1;
      if (!line) begin
         if (rx_prev_high) begin
            rx_prev_high = 1'b0;
            rx_measure();
            rx_width = 8'd0;
         end
      end else begin
         rx_prev_high = 1'b1;
      end
   endfunction

   // Apply one request and return the status it leaves
   function automatic link_status_type predict_status(func_type fn, logic line,
                                                      logic [5:0] idx, logic [7:0] data,
                                                      logic last);
      link_status_type s;
      s.rd_data = 8'd0;
      case (fn)
         FN_TICK: begin
            if (tx_on) tx_advance();
            rx_sample(line);
         end
         FN_WRITE: begin
            if (idx < TX_BYTES) begin
               tx_bytes[idx] = data;
               if (last) begin
                  tx_ticks = 5'd0;
                  tx_phase = PH_HEAD;
                  tx_on = 1'b1;
               end
            end
         end
         FN_READ: begin
            if (idx < RX_BYTES) s.rd_data = rx_bytes[idx];
         end
         default: rx_complete = 1'b0;
      endcase
      s.tx_line = tx_level;
      s.tx_busy = tx_on;
      s.rx_done = rx_complete;
      return s;
   endfunction

   always @(posedge clock) begin
      link_status_type want;
      link_status_type got;
      if (reset) begin
         foreach (tx_bytes[i]) tx_bytes[i] = 8'd0;
         foreach (rx_bytes[i]) rx_bytes[i] = 8'd0;
         tx_ticks = 5'd0;
         tx_mask = 8'd0;
         tx_pos = 6'd0;
         tx_phase = PH_IDLE;
         tx_on = 1'b0;
         tx_level = 1'b1;
         rx_mask = 8'd0;
         rx_pos = 7'd0;
         rx_width = 8'd0;
         rx_active = 1'b0;
         rx_complete = 1'b0;
         rx_prev_high = 1'b0;
         status_queue.delete();
         errors = 0;
         result_count = 0;
      end else begin
         // compare a delivered result with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.tx_line = rsp_tdata[0];
            got.tx_busy = rsp_tdata[1];
            got.rx_done = rsp_tdata[2];
            got.rd_data = rsp_tdata[10:3];
            if (status_queue.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("result %0d arrived with no request outstanding", result_count);
            end else begin
               want = status_queue.pop_front();
               if (got.tx_line !== want.tx_line || got.tx_busy !== want.tx_busy ||
                   got.rx_done !== want.rx_done || got.rd_data !== want.rd_data) begin
                  errors++;
                  if (errors <= 10)
                     $display("result %0d: expected tx_line %0d tx_busy %0d rx_done %0d",
                              result_count, want.tx_line, want.tx_busy, want.rx_done,
                              " rd_data %02h, got tx_line %0d tx_busy %0d rx_done %0d",
                              want.rd_data, got.tx_line, got.tx_busy, got.rx_done,
                              " rd_data %02h", got.rd_data);
               end
            end
            result_count++;
         end
         // predict the result of an accepted request
         if (req_tvalid && req_tready)
            status_queue.push_back(predict_status(func_type'(req_tuser), req_tdata[0],
                                                  req_tdata[6:1], req_tdata[14:7],
                                                  req_tlast));
      end
      mismatch_count <= errors;
      pending_count <= status_queue.size();
   end

endmodule

// ===== bench/testbench.sv =====
// Stimulus and verdict for the pulse-width serial link: host accesses and receive waveforms.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pwsl_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   int          mismatch_count;
   int          pending_count;
   int          cycle_count = 0;
   bit          no_gaps = 1'b0;

   pulse_width_serial_link_top uut (.*);

   pulse_width_link_checker link_monitor (.*);

   always #1 clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Present one request after a random gap and hold it until taken
   task automatic send_request(func_type fn, logic line, logic [5:0] idx, logic [7:0] data,
                               logic last);
      int gap;
      if ($urandom_range(0, 63) == 0) no_gaps = !no_gaps;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= fn;
      req_tdata <= {1'b0, data, idx, line};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_tick(logic line);
      send_request(FN_TICK, line, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
   endtask

   // Random host access; mostly in-range positions, a start only when allowed
   task automatic send_host_op(bit allow_start);
      int pick;
      logic [5:0] idx;
      pick = $urandom_range(0, 7);
      idx = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(16, 63)) : 6'($urandom_range(0, 15));
      if (pick < 4)
         send_request(FN_WRITE, 1'($urandom_range(0, 1)), idx, 8'($urandom_range(0, 255)),
                      allow_start && ($urandom_range(0, 19) == 0));
      else if (pick < 7)
         send_request(FN_READ, 1'($urandom_range(0, 1)), idx, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
      else
         send_request(FN_CLEAR, 1'($urandom_range(0, 1)), idx, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
   endtask

   // Hold the receive line for a number of ticks, with host accesses mixed in
   task automatic hold_line(logic line, int count, bit allow_start);
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) send_host_op(allow_start);
         send_tick(line);
      end
   endtask

   // One period: a few low ticks, then high up to the given width
   task automatic send_period(int width, bit allow_start);
      int low;
      low = (width > 5) ? $urandom_range(1, 5) : ((width > 1) ? $urandom_range(1, width - 1) : 1);
      hold_line(1'b0, low, allow_start);
      hold_line(1'b1, width - low, allow_start);
   endtask

   // Header, random bits, end period; one bit may carry a bad width
   task automatic send_frame(int nbytes, int bad_bit, bit allow_start);
      hold_line(1'b1, $urandom_range(1, 4), allow_start);
      send_period($urandom_range(17, 23), allow_start);
      for (int b = 0; b < nbytes * 8; b++) begin
         int w;
         if (b == bad_bit) begin
            case ($urandom_range(0, 2))
               0: w = 17;
               1: w = $urandom_range(1, 7);
               default: w = $urandom_range(24, 60);
            endcase
         end else if ($urandom_range(0, 1) != 0) begin
            w = $urandom_range(13, 16);
         end else begin
            w = $urandom_range(8, 12);
         end
         send_period(w, allow_start);
      end
      // the falling edge of the end period judges the last bit
      send_period($urandom_range(5, 30), allow_start);
   endtask

   // Accept results after a random stall per result
   initial begin
      int gap;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = no_gaps ? 0 : $urandom_range(0, 4);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= FN_TICK;
      req_tlast <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty buffers, out-of-range accesses, starts and a restart
      send_request(FN_READ, 1'b1, 6'd0, 8'hFF, 1'b1);
      send_request(FN_READ, 1'b0, 6'd63, 8'h00, 1'b0);
      send_request(FN_CLEAR, 1'b1, 6'd63, 8'hFF, 1'b1);
      send_request(FN_WRITE, 1'b0, 6'd0, 8'hFF, 1'b0);
      send_request(FN_WRITE, 1'b1, 6'd15, 8'h00, 1'b0);
      send_request(FN_WRITE, 1'b0, 6'd63, 8'hAA, 1'b1);
      send_request(FN_WRITE, 1'b1, 6'd16, 8'h55, 1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_request(FN_WRITE, 1'b0, 6'd1, 8'h80, 1'b1);
      send_request(FN_TICK, 1'b1, 6'd63, 8'hFF, 1'b1);
      send_request(FN_TICK, 1'b1, 6'd0, 8'h00, 1'b0);
      send_tick(1'b1);
      send_request(FN_WRITE, 1'b1, 6'd2, 8'h01, 1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_request(FN_READ, 1'b1, 6'd15, 8'h00, 1'b0);
      send_request(FN_READ, 1'b0, 6'd16, 8'hFF, 1'b1);
      send_request(FN_CLEAR, 1'b0, 6'd0, 8'h00, 1'b0);

      // Fill the transmit buffer and start a frame
      for (int i = 0; i < TX_BYTES; i++)
         send_request(FN_WRITE, 1'($urandom_range(0, 1)), 6'(i), 8'($urandom_range(0, 255)),
                      i == TX_BYTES - 1);
      // Full well-formed receive frame while the transmitter runs
      send_frame(RX_BYTES, -1, 1'b0);
      for (int i = 0; i < RX_BYTES; i++)
         send_request(FN_READ, 1'($urandom_range(0, 1)), 6'(i), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
      send_request(FN_CLEAR, 1'b0, 6'd0, 8'h00, 1'b0);

      // Long high stretch so the width counter wraps
      hold_line(1'b1, $urandom_range(256, 280), 1'b1);
      hold_line(1'b0, 1, 1'b1);

      // Short frames, broken frames and line noise
      send_frame(1, $urandom_range(0, 7), 1'b1);
      send_frame(1, -1, 1'b1);
      repeat (40) hold_line(1'($urandom_range(0, 1)), 1, 1'b1);
      req_tvalid <= 1'b0;

      // Drain outstanding results
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
